FILE: rtl/ddo_pkg.sv
// Shared types, constants and the CORDIC angle table for the odometry core.
`timescale 1ns / 1ps
package ddo_pkg;

   localparam int ANGLE_BITS_DEF = 32;
   localparam int CORDIC_ITERS   = 30;
   localparam int POS_W          = 56;
   localparam int WIDTH_W        = 11;

   localparam logic [WIDTH_W-1:0] TRACK_RESET = 11'd422;
   localparam logic [32:0]        CORDIC_START = 33'd652032874;
   localparam logic [25:0]        TURN_K       = 26'd44798134;
   localparam logic [25:0]        AV_MAX       = 26'd655350;

   // register index carried on csr_paddr[2]
   localparam logic CSR_TRACK_IDX = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_RUN_A,
      ST_START_B,
      ST_RUN_B,
      ST_ROUND,
      ST_RUN_DIV,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic start_a;
      logic start_b;
      logic start_div;
      logic update;
   } ctl_type;

   // atan(2^-i) in binary angle units, full turn = 2^32
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/ddo_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module ddo_mul
   import ddo_pkg::*;
#(
   parameter int AW = 32,
   parameter int BW = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             busy,
   output logic [AW+BW-1:0] product
);
   localparam int CW = (BW > 1) ? $clog2(BW) : 1;

   logic [AW-1:0] a_ff, a_in;
   logic [AW:0]   acc_ff, acc_in, sum;
   logic [BW-1:0] low_ff, low_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;

   always_comb begin
      sum     = low_ff[0] ? (acc_ff + {1'b0, a_ff}) : acc_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = a;
         acc_in  = '0;
         low_in  = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the partial product right, one multiplier bit retired
         acc_in = sum >> 1;
         low_in = {sum[0], low_ff[BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
      low_ff <= low_in;
   end

   assign busy    = busy_ff;
   assign product = {acc_ff[AW-1:0], low_ff};

endmodule

FILE: rtl/ddo_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ddo_div
   import ddo_pkg::*;
#(
   parameter int NW = 45,
   parameter int DW = WIDTH_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quot
);
   localparam int CW = $clog2(NW);

   logic [DW-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   r2, diff;
   logic          ge;

   always_comb begin
      r2      = {rem_ff, quo_ff[NW-1]};
      diff    = r2 - {1'b0, den_ff};
      ge      = (r2 >= {1'b0, den_ff});
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         den_in  = den;
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : r2[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

FILE: rtl/diff_drive_odometry_core.sv
// Top level of the differential-drive odometry integrator.
// Per item: 30 CORDIC iterations, a bit-serial 34-bit multiply and a 45-bit restoring
// heading divide, with handover states between them. A new item is taken only when idle,
// after the last one is done; the serial multiply and divide units work on one item at
// a time. A result held by a stalled receiver holds the next pose update.
// Reset: synchronous, active high; pose clears to zero, track width to 422 mm.
`timescale 1ns / 1ps
module diff_drive_odometry_core
   import ddo_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // left_speed[15:0], right_speed[31:16], elapsed_us[49:32]
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [183:0] rsp_tdata,   // pos_x[55:0], pos_y[111:56], heading[143:112],
                                     // linear_velocity[159:144], angular_velocity[180:160]
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   // clear the angle bits below the configured resolution
   localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   state_type state_ff, state_in;
   ctl_type   ctl;

   // ---------------- configuration ----------------
   logic [WIDTH_W-1:0] track_ff, track_in, w_eff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      track_in = track_ff;
      if (csr_wr && (csr_paddr[2] == CSR_TRACK_IDX)) begin
         track_in = csr_pwdata[WIDTH_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_TRACK_IDX) ? {21'd0, track_ff} : 32'd0;
   // a zero width behaves as one millimetre
   assign w_eff = (track_ff == '0) ? WIDTH_W'(1) : track_ff;

   // ---------------- captured item ----------------
   logic signed [15:0] vl_ff, vl_in, vr_ff, vr_in;
   logic [17:0]        t_ff, t_in;
   logic               req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      vl_in = vl_ff;
      vr_in = vr_ff;
      t_in  = t_ff;
      if (req_fire) begin
         vl_in = req_tdata[15:0];
         vr_in = req_tdata[31:16];
         t_in  = req_tdata[49:32];
      end
   end

   logic signed [16:0] sum_s, dif_s;
   logic [16:0]        sum_mag, dif_mag;
   logic [26:0]        av_prod;
   logic [25:0]        av_num;

   assign sum_s   = $signed({vl_ff[15], vl_ff}) + $signed({vr_ff[15], vr_ff});
   assign dif_s   = $signed({vr_ff[15], vr_ff}) - $signed({vl_ff[15], vl_ff});
   assign sum_mag = sum_s[16] ? (17'd0 - $unsigned(sum_s)) : $unsigned(sum_s);
   assign dif_mag = dif_s[16] ? (17'd0 - $unsigned(dif_s)) : $unsigned(dif_s);
   // |dv| * 1000 by shifts, plus half the width for rounding
   assign av_prod = ({10'd0, dif_mag} << 10) - ({10'd0, dif_mag} << 4)
                  - ({10'd0, dif_mag} << 3) + {16'd0, (w_eff >> 1)};
   assign av_num  = av_prod[25:0];

   // ---------------- CORDIC ----------------
   logic signed [32:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [32:0] xs, ys, at;
   logic [4:0]         citer_ff, citer_in;
   logic               cbusy_ff, cbusy_in, cflip_ff, cflip_in;
   logic [31:0]        ang_m;
   logic               ang_flip;
   logic [31:0]        heading_ff, heading_in;

   assign ang_m    = heading_ff & ANGLE_MASK;
   assign ang_flip = ang_m[31] ^ ang_m[30];
   assign xs       = cx_ff >>> citer_ff;
   assign ys       = cy_ff >>> citer_ff;
   assign at       = $signed({1'b0, atan_entry(citer_ff)});

   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      citer_in = citer_ff;
      cbusy_in = cbusy_ff;
      cflip_in = cflip_ff;
      if (ctl.start_a) begin
         // fold the angle into the right half plane, negate the result later
         cx_in    = $signed(CORDIC_START);
         cy_in    = '0;
         cz_in    = $signed({ang_m[31] ^ ang_flip, ang_m[31] ^ ang_flip, ang_m[30:0]});
         citer_in = '0;
         cbusy_in = 1'b1;
         cflip_in = ang_flip;
      end else if (cbusy_ff) begin
         if (!cz_ff[32]) begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            cz_in = cz_ff - at;
         end else begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            cz_in = cz_ff + at;
         end
         citer_in = citer_ff + 5'd1;
         if (citer_ff == 5'(CORDIC_ITERS - 1)) begin
            cbusy_in = 1'b0;
         end
      end
   end

   logic signed [32:0] c_full, s_full;
   logic [31:0]        c_mag, s_mag;

   assign c_full = cflip_ff ? -cx_ff : cx_ff;
   assign s_full = cflip_ff ? -cy_ff : cy_ff;
   assign c_mag  = c_full[32] ? 32'(-c_full) : c_full[31:0];
   assign s_mag  = s_full[32] ? 32'(-s_full) : s_full[31:0];

   // ---------------- serial arithmetic units ----------------
   logic [34:0] prod_s, prod_d;
   logic [65:0] prod_x, prod_y;
   logic [59:0] prod_h;
   logic [25:0] quot_a;
   logic [44:0] quot_h, hnum;
   logic        bs_s, bs_d, bs_x, bs_y, bs_h, bs_a, bs_dh;

   ddo_mul #(.AW(17), .BW(18)) u_mul_s (
      .clock(clock), .reset(reset), .start(ctl.start_a),
      .a(sum_mag), .b(t_ff), .busy(bs_s), .product(prod_s));

   ddo_mul #(.AW(17), .BW(18)) u_mul_d (
      .clock(clock), .reset(reset), .start(ctl.start_a),
      .a(dif_mag), .b(t_ff), .busy(bs_d), .product(prod_d));

   ddo_mul #(.AW(32), .BW(34)) u_mul_x (
      .clock(clock), .reset(reset), .start(ctl.start_b),
      .a(c_mag), .b(prod_s[33:0]), .busy(bs_x), .product(prod_x));

   ddo_mul #(.AW(32), .BW(34)) u_mul_y (
      .clock(clock), .reset(reset), .start(ctl.start_b),
      .a(s_mag), .b(prod_s[33:0]), .busy(bs_y), .product(prod_y));

   ddo_mul #(.AW(26), .BW(34)) u_mul_h (
      .clock(clock), .reset(reset), .start(ctl.start_b),
      .a(TURN_K), .b(prod_d[33:0]), .busy(bs_h), .product(prod_h));

   ddo_div #(.NW(26), .DW(WIDTH_W)) u_div_a (
      .clock(clock), .reset(reset), .start(ctl.start_a),
      .num(av_num), .den(w_eff), .busy(bs_a), .quot(quot_a));

   ddo_div #(.NW(45), .DW(WIDTH_W)) u_div_h (
      .clock(clock), .reset(reset), .start(ctl.start_div),
      .num(hnum), .den(w_eff), .busy(bs_dh), .quot(quot_h));

   // ---------------- rounding of the displacement ----------------
   logic [66:0] rsum_x, rsum_y;
   logic [60:0] hsum;
   logic [34:0] rx, ry;
   logic signed [35:0] dx_ff, dx_in, dy_ff, dy_in;
   logic        negx_ff, negx_in, negy_ff, negy_in;

   assign rsum_x = {1'b0, prod_x} + (67'd1 << 30);
   assign rsum_y = {1'b0, prod_y} + (67'd1 << 30);
   assign rx     = rsum_x[65:31];
   assign ry     = rsum_y[65:31];
   // divide by width * 2^16: round at 2^16 first, then divide by the width
   assign hsum   = {1'b0, prod_h} + {35'd0, w_eff, 15'd0};
   assign hnum   = hsum[60:16];

   always_comb begin
      negx_in = negx_ff;
      negy_in = negy_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      if (ctl.start_b) begin
         negx_in = sum_s[16] ^ c_full[32];
         negy_in = sum_s[16] ^ s_full[32];
      end
      if (ctl.start_div) begin
         dx_in = negx_ff ? $signed(36'd0 - {1'b0, rx}) : $signed({1'b0, rx});
         dy_in = negy_ff ? $signed(36'd0 - {1'b0, ry}) : $signed({1'b0, ry});
      end
   end

   // ---------------- pose update and result register ----------------
   logic signed [POS_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [POS_W:0]          sum_x, sum_y;
   logic [19:0]             mav;
   logic [15:0]             lv_ff, lv_in;
   logic [20:0]             av_ff, av_in;
   logic                    rsp_valid_ff, rsp_valid_in, update_fire;

   assign update_fire = ctl.update && (!rsp_valid_ff || rsp_tready);
   assign sum_x = {x_ff[POS_W-1], x_ff} + {{(POS_W-35){dx_ff[35]}}, dx_ff};
   assign sum_y = {y_ff[POS_W-1], y_ff} + {{(POS_W-35){dy_ff[35]}}, dy_ff};
   // clamp the angular rate magnitude
   assign mav   = (quot_a > AV_MAX) ? AV_MAX[19:0] : quot_a[19:0];

   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      heading_in   = heading_ff;
      lv_in        = lv_ff;
      av_in        = av_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (update_fire) begin
         // saturate on overflow of the signed position
         if (sum_x[POS_W] != sum_x[POS_W-1]) begin
            x_in = sum_x[POS_W] ? POS_MIN : POS_MAX;
         end else begin
            x_in = sum_x[POS_W-1:0];
         end
         if (sum_y[POS_W] != sum_y[POS_W-1]) begin
            y_in = sum_y[POS_W] ? POS_MIN : POS_MAX;
         end else begin
            y_in = sum_y[POS_W-1:0];
         end
         // heading wraps modulo a full turn
         heading_in   = dif_s[16] ? (heading_ff - quot_h[31:0])
                                  : (heading_ff + quot_h[31:0]);
         lv_in        = sum_s[16:1];
         av_in        = dif_s[16] ? (21'd0 - {1'b0, mav}) : {1'b0, mav};
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, av_ff, lv_ff, heading_ff, y_ff, x_ff};

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) begin
                        state_in = ST_START;
                     end
         ST_START:   state_in = ST_RUN_A;
         ST_RUN_A:   if (!cbusy_ff && !bs_s && !bs_d) begin
                        state_in = ST_START_B;
                     end
         ST_START_B: state_in = ST_RUN_B;
         ST_RUN_B:   if (!bs_x && !bs_y && !bs_h) begin
                        state_in = ST_ROUND;
                     end
         ST_ROUND:   state_in = ST_RUN_DIV;
         ST_RUN_DIV: if (!bs_dh && !bs_a) begin
                        state_in = ST_UPDATE;
                     end
         ST_UPDATE:  if (!rsp_valid_ff || rsp_tready) begin
                        state_in = ST_IDLE;
                     end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl           = '0;
      ctl.start_a   = (state_ff == ST_START);
      ctl.start_b   = (state_ff == ST_START_B);
      ctl.start_div = (state_ff == ST_ROUND);
      ctl.update    = (state_ff == ST_UPDATE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         track_ff     <= TRACK_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cbusy_ff     <= 1'b0;
         citer_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         track_ff     <= track_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
         cbusy_ff     <= cbusy_in;
         citer_ff     <= citer_in;
      end
      vl_ff    <= vl_in;
      vr_ff    <= vr_in;
      t_ff     <= t_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      cflip_ff <= cflip_in;
      negx_ff  <= negx_in;
      negy_ff  <= negy_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      lv_ff    <= lv_in;
      av_ff    <= av_in;
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_START))
      else $error("accepted item did not start processing");

   a_update_presents: assert property (@(posedge clock) disable iff (reset)
      update_fire |=> rsp_tvalid)
      else $error("pose update without a result");

   a_cordic_window: assert property (@(posedge clock) disable iff (reset)
      cbusy_ff |-> (state_ff == ST_RUN_A))
      else $error("CORDIC running outside its phase");
`endif

endmodule
